@@ rtl/accumulator_stack_cpu_step_assert.svh @@
// Assertion macros shared by the accumulator stack CPU modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ACCUMULATOR_STACK_CPU_STEP_ASSERT_SVH
`define ACCUMULATOR_STACK_CPU_STEP_ASSERT_SVH

// The expression must never hold at a clock edge.
`define ASCS_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// When the first expression holds, the second holds in the same cycle.
`define ASCS_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the first expression holds, the second holds in the next cycle.
`define ASCS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ascs_pkg.sv @@
// Package for the accumulator stack CPU: payload structs, opcodes, status codes.
// Used by every module of the block; depends on nothing.
package ascs_pkg;

    // Fixed field widths.
    localparam int DATA_W            = 32;
    localparam int DEPTH_W           = 10;
    localparam int STATUS_W          = 3;
    localparam int OPC_W             = 4;
    localparam int STACK_ENTRIES_DEF = 512;
    localparam int QUEUE_DEPTH       = 2;

    // Opcodes as they arrive on the command channel.
    localparam logic [OPC_W-1:0] OPC_NOP  = 4'd0;
    localparam logic [OPC_W-1:0] OPC_ADD  = 4'd1;
    localparam logic [OPC_W-1:0] OPC_SUB  = 4'd2;
    localparam logic [OPC_W-1:0] OPC_MUL  = 4'd3;
    localparam logic [OPC_W-1:0] OPC_DIV  = 4'd4;
    localparam logic [OPC_W-1:0] OPC_MOVA = 4'd5;
    localparam logic [OPC_W-1:0] OPC_LOAD = 4'd6;
    localparam logic [OPC_W-1:0] OPC_SWAC = 4'd7;
    localparam logic [OPC_W-1:0] OPC_SWAB = 4'd8;
    localparam logic [OPC_W-1:0] OPC_INC  = 4'd9;
    localparam logic [OPC_W-1:0] OPC_DEC  = 4'd10;
    localparam logic [OPC_W-1:0] OPC_PUSH = 4'd11;
    localparam logic [OPC_W-1:0] OPC_POP  = 4'd12;

    // Status codes reported with each result.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_OP     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOAD_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    // Decoded operation kind handed from the front end to the back end.
    typedef enum logic [3:0] {
        K_NOP,
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_MOVA,
        K_LOAD,
        K_SWAC,
        K_SWAB,
        K_INC,
        K_DEC,
        K_PUSH,
        K_POP,
        K_BAD
    } ascs_kind_t;

    // Back-end execution states.
    typedef enum logic [1:0] {
        EX_IDLE,
        EX_LOAD,
        EX_DIV
    } ascs_state_t;

    // Command transaction payload.
    typedef struct packed {
        logic        [OPC_W-1:0]  action;
        logic signed [DATA_W-1:0] argument;
    } ascs_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic signed [DATA_W-1:0]   reg_a;
        logic signed [DATA_W-1:0]   reg_b;
        logic signed [DATA_W-1:0]   reg_c;
        logic        [DEPTH_W-1:0]  depth;
        logic        [STATUS_W-1:0] status;
    } ascs_out_t;

    // Decoded micro-operation held in the queue.
    typedef struct packed {
        ascs_kind_t               kind;
        logic signed [DATA_W-1:0] arg;
    } ascs_uop_t;

endpackage

@@ rtl/ascs_front.sv @@
// Front end: accepts command transactions, decodes the opcode and queues the result.
// Depends on ascs_pkg and the assertion macro header.
`include "accumulator_stack_cpu_step_assert.svh"

module ascs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ascs_pkg::ascs_in_t cmd,
    output logic               uop_valid,
    input  logic               uop_pop,
    output ascs_pkg::ascs_uop_t uop
);
    import ascs_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    ascs_uop_t           q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]   q_cnt_reg;
    logic [QCNT_W-1:0]   q_cnt_next;
    logic                push;
    ascs_uop_t           decoded;

    // Decode the opcode into an operation kind.
    always_comb
    begin
        decoded.arg = cmd.argument;
        case (cmd.action)
            OPC_NOP:  decoded.kind = K_NOP;
            OPC_ADD:  decoded.kind = K_ADD;
            OPC_SUB:  decoded.kind = K_SUB;
            OPC_MUL:  decoded.kind = K_MUL;
            OPC_DIV:  decoded.kind = K_DIV;
            OPC_MOVA: decoded.kind = K_MOVA;
            OPC_LOAD: decoded.kind = K_LOAD;
            OPC_SWAC: decoded.kind = K_SWAC;
            OPC_SWAB: decoded.kind = K_SWAB;
            OPC_INC:  decoded.kind = K_INC;
            OPC_DEC:  decoded.kind = K_DEC;
            OPC_PUSH: decoded.kind = K_PUSH;
            OPC_POP:  decoded.kind = K_POP;
            default:  decoded.kind = K_BAD;
        endcase
    end

    // Queue handshakes: stall when full, offer the oldest entry.
    assign cmd_stall = (q_cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = cmd_valid && !cmd_stall;
    assign uop_valid = (q_cnt_reg != '0);
    assign uop       = q_mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (uop_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !uop_pop)
        begin
            q_cnt_next = q_cnt_reg + 1'b1;
        end
        else if (!push && uop_pop)
        begin
            q_cnt_next = q_cnt_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= decoded;
        end
    end

    `ASCS_NEVER(a_q_overflow, q_cnt_reg > QCNT_W'(QUEUE_DEPTH), "queue count above depth")
    `ASCS_IMPLY(a_pop_nonempty, uop_pop, q_cnt_reg != '0, "pop from empty queue")
    `ASCS_NEXT(a_push_counts, push && !uop_pop, q_cnt_reg == $past(q_cnt_reg) + 1'b1, "push lost")

endmodule

@@ rtl/ascs_div.sv @@
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
// Depends on ascs_pkg.
module ascs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ascs_pkg::DATA_W-1:0] dividend,
    input  logic [ascs_pkg::DATA_W-1:0] divisor,
    output logic                        busy,
    output logic [ascs_pkg::DATA_W-1:0] quotient
);
    import ascs_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic                busy_reg;
    logic                busy_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   rem_next;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   quo_next;
    logic [DATA_W-1:0]   den_reg;
    logic [DATA_W-1:0]   den_next;
    logic                neg_reg;
    logic                neg_next;
    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     trial;

    // One restoring step on the magnitudes.
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            den_next  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_next  = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_next  = {quo_reg[DATA_W-2:0], !trial[DATA_W]};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

@@ rtl/ascs_back.sv @@
// Back end: executes decoded operations on A, B, C and the stack, registers results.
// Depends on ascs_pkg, ascs_div and the assertion macro header.
`include "accumulator_stack_cpu_step_assert.svh"

module ascs_back #(
    parameter int STACK_ENTRIES = ascs_pkg::STACK_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                uop_valid,
    input  ascs_pkg::ascs_uop_t uop,
    output logic                uop_pop,
    output logic                res_valid,
    input  logic                res_stall,
    output ascs_pkg::ascs_out_t res
);
    import ascs_pkg::*;

    localparam int AW = $clog2(STACK_ENTRIES);
    localparam int CW = $clog2(STACK_ENTRIES + 1);

    ascs_state_t          state_reg;
    ascs_state_t          state_next;
    logic [DATA_W-1:0]    a_reg;
    logic [DATA_W-1:0]    a_next;
    logic [DATA_W-1:0]    b_reg;
    logic [DATA_W-1:0]    b_next;
    logic [DATA_W-1:0]    c_reg;
    logic [DATA_W-1:0]    c_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 res_valid_reg;
    ascs_out_t            res_reg;
    ascs_out_t            res_next;
    logic                 res_load;
    logic [STATUS_W-1:0]  status;
    logic                 slot_free;
    logic                 take;
    logic [DATA_W-1:0]    count_w;
    logic [DATA_W-1:0]    count_w_next;
    logic                 load_ok;
    logic                 stack_full;
    logic [DATA_W-1:0]    mul_lo;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 mem_we;
    logic                 mem_re;
    logic [DATA_W-1:0]    stack_mem [STACK_ENTRIES];
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 div_start;
    logic                 div_busy;
    logic [DATA_W-1:0]    div_quotient;

    // Divider used by the DIV operation.
    ascs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (c_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Issue conditions and operand checks.
    assign slot_free  = !res_valid_reg || !res_stall;
    assign take       = (state_reg == EX_IDLE) && uop_valid && slot_free;
    assign uop_pop    = take;
    assign count_w    = DATA_W'(count_reg);
    assign load_ok    = !b_reg[DATA_W-1] && (b_reg < count_w);
    assign stack_full = (count_reg >= CW'(STACK_ENTRIES));
    assign mul_lo     = a_reg * c_reg;
    assign rd_addr    = AW'(count_w - DATA_W'(1) - b_reg);
    assign wr_addr    = count_reg[AW-1:0];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EX_IDLE:
            begin
                if (take && uop.kind == K_LOAD && load_ok)
                begin
                    state_next = EX_LOAD;
                end
                else if (take && uop.kind == K_DIV && c_reg != '0)
                begin
                    state_next = EX_DIV;
                end
            end
            EX_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = EX_IDLE;
                end
            end
            EX_DIV:
            begin
                if (!div_busy && slot_free)
                begin
                    state_next = EX_IDLE;
                end
            end
            default:
            begin
                state_next = EX_IDLE;
            end
        endcase
    end

    // Datapath and output control.
    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        count_next = count_reg;
        status     = ST_OK;
        res_load   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            EX_IDLE:
            begin
                if (take)
                begin
                    res_load = 1'b1;
                    case (uop.kind)
                        K_NOP:  a_next = a_reg;
                        K_ADD:  a_next = a_reg + c_reg;
                        K_SUB:  a_next = a_reg - c_reg;
                        K_MUL:  a_next = mul_lo;
                        K_DIV:
                        begin
                            if (c_reg == '0)
                            begin
                                status = ST_DIV_ZERO;
                            end
                            else
                            begin
                                div_start = 1'b1;
                                res_load  = 1'b0;
                            end
                        end
                        K_MOVA: a_next = uop.arg;
                        K_LOAD:
                        begin
                            if (load_ok)
                            begin
                                mem_re   = 1'b1;
                                res_load = 1'b0;
                            end
                            else
                            begin
                                status = ST_LOAD_RANGE;
                            end
                        end
                        K_SWAC:
                        begin
                            a_next = c_reg;
                            c_next = a_reg;
                        end
                        K_SWAB:
                        begin
                            a_next = b_reg;
                            b_next = a_reg;
                        end
                        K_INC:  a_next = a_reg + DATA_W'(1);
                        K_DEC:  a_next = a_reg - DATA_W'(1);
                        K_PUSH:
                        begin
                            if (stack_full)
                            begin
                                status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        K_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default: status = ST_BAD_OP;
                    endcase
                end
            end
            EX_LOAD:
            begin
                if (slot_free)
                begin
                    a_next   = rd_data_reg;
                    res_load = 1'b1;
                end
            end
            EX_DIV:
            begin
                if (!div_busy && slot_free)
                begin
                    a_next   = div_quotient;
                    res_load = 1'b1;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // Result word built from the updated state.
    assign count_w_next = DATA_W'(count_next);

    always_comb
    begin
        res_next.reg_a  = a_next;
        res_next.reg_b  = b_next;
        res_next.reg_c  = c_next;
        res_next.depth  = count_w_next[DEPTH_W-1:0];
        res_next.status = status;
    end

    // Control and architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EX_IDLE;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            count_reg <= count_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    // Stack memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= a_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `ASCS_NEVER(a_count_range, count_reg > CW'(STACK_ENTRIES), "stack depth above capacity")
    `ASCS_IMPLY(a_div_nonzero, div_start, c_reg != '0, "divider started with zero divisor")
    `ASCS_NEXT(a_div_finish, state_reg == EX_DIV && !div_busy && slot_free, state_reg == EX_IDLE && res_valid_reg, "division result not delivered")
    `ASCS_IMPLY(a_issue_valid, uop_pop, uop_valid && state_reg == EX_IDLE, "issue without a queued operation")

endmodule

@@ rtl/accumulator_stack_cpu_step.sv @@
// Path: a command is registered in the decode queue, then executed with its result registered;
// load also passes the registered stack memory read, div the 32-step iterative divider.
// Throughput: one instruction per cycle for register and stack ops while res_stall is low;
// load and div hold the single execute unit until their result is registered, setting the pace.
// Reset: asynchronous, active low; clears A, B, C, stack depth, queue and result valid.
// Stack contents are not cleared, so there is no clearing pass after reset.
module accumulator_stack_cpu_step #(
    parameter int STACK_ENTRIES = ascs_pkg::STACK_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ascs_pkg::ascs_in_t  cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output ascs_pkg::ascs_out_t res
);
    import ascs_pkg::*;

    logic      uop_valid;
    logic      uop_pop;
    ascs_uop_t uop;

    // Front end: decode and queue.
    ascs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .uop_valid (uop_valid),
        .uop_pop   (uop_pop),
        .uop       (uop)
    );

    // Back end: execute and register results.
    ascs_back #(
        .STACK_ENTRIES (STACK_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop_valid (uop_valid),
        .uop       (uop),
        .uop_pop   (uop_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
